@@ design/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros : assertion helpers
// clocked assertion wrappers used by the top level alone among the decoder files
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define UTF8D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define UTF8D_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/utf8d_pkg.sv @@
// -----------------------------------------------------------------------------
// utf8d_pkg : decoder types, constants and byte step functions
// shared result, state and queue entry types plus the per byte decode step
// -----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int NUM_SLOTS = 5;

   localparam logic [7:0]  LEAD_SURROGATE    = 8'hED;
   localparam logic [3:0]  LOW_SURROGATE_NIB = 4'hB;
   localparam logic [7:0]  LEAD_MIN          = 8'hC0;
   localparam logic [7:0]  LEAD_MAX          = 8'hF7;
   localparam logic [5:0]  HIGH_SURR_TAG     = 6'b110110;

   localparam logic [20:0] CP_REPLACEMENT    = 21'h00003F;
   localparam logic [20:0] CP_LIMIT          = 21'h110000;
   localparam logic [20:0] SURR_FIRST        = 21'h00D800;
   localparam logic [20:0] SURR_LAST         = 21'h00DFFF;
   localparam logic [20:0] NONCHAR_FIRST     = 21'h00FDD0;
   localparam logic [20:0] NONCHAR_LAST      = 21'h00FDEF;
   localparam logic [15:0] NONCHAR_LOW16     = 16'hFFFE;
   localparam logic [20:0] MIN_TWO_BYTE      = 21'h000080;
   localparam logic [20:0] MIN_THREE_BYTE    = 21'h000800;
   localparam logic [20:0] SUPP_BASE         = 21'h010000;

   localparam logic [2:0]  SEQ_LEN_ONE       = 3'd1;
   localparam logic [2:0]  SEQ_LEN_TWO       = 3'd2;
   localparam logic [2:0]  SEQ_LEN_THREE     = 3'd3;
   localparam logic [2:0]  SEQ_LEN_FOUR      = 3'd4;
   localparam logic [2:0]  SEQ_LEN_PAIR      = 3'd6;

   typedef struct packed {
      logic [20:0] code_point;
      logic        had_error;
      logic [2:0]  seq_length;
   } result_type;

   typedef struct packed {
      logic [20:0] value;
      logic [2:0]  count;
      logic [1:0]  held_count;
   } dec_state_type;

   typedef struct packed {
      logic          emit;
      result_type    res;
      dec_state_type st;
      logic          refeed;
   } feed_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]         mask;
      result_type [NUM_SLOTS-1:0]   slot;
      logic                         last;
      logic                         string_valid;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   localparam dec_state_type STATE_CLEAR = '0;

   function automatic logic scalar_ok(input logic [20:0] v);
      return (v < CP_LIMIT) && !((v >= SURR_FIRST) && (v <= SURR_LAST)) &&
             (v[15:0] < NONCHAR_LOW16) && !((v >= NONCHAR_FIRST) && (v <= NONCHAR_LAST));
   endfunction

   function automatic result_type error_result(input logic [2:0] len);
      result_type r;
      r.code_point = CP_REPLACEMENT;
      r.had_error  = 1'b1;
      r.seq_length = len;
      return r;
   endfunction

   function automatic result_type finish(input logic [20:0] v, input logic [20:0] min_value,
                                         input logic [2:0] len);
      result_type r;
      if ((v >= min_value) && scalar_ok(v)) begin
         r.code_point = v;
         r.had_error  = 1'b0;
         r.seq_length = len;
      end else begin
         r = error_result(len);
      end
      return r;
   endfunction

   // state left after a lone high surrogate has its held bytes decoded again
   function automatic dec_state_type replay_state(input logic [1:0] hc, input logic [7:0] held);
      dec_state_type s;
      s = STATE_CLEAR;
      case (hc)
         2'd0: s = STATE_CLEAR;
         2'd1: begin
            s.value = {13'd0, LEAD_SURROGATE};
            s.count = 3'd1;
         end
         default: begin
            s.value = {9'd0, LEAD_SURROGATE[5:0], held[5:0]};
            s.count = 3'd2;
         end
      endcase
      return s;
   endfunction

   // one byte into a sequence that is not waiting for a low surrogate
   function automatic feed_type feed_byte(input dec_state_type s, input logic [7:0] b);
      feed_type        f;
      logic [11:0]     v2;
      logic [16:0]     v3;
      logic [20:0]     v4;
      f.emit          = 1'b0;
      f.res           = '0;
      f.st            = s;
      f.st.held_count = 2'd0;
      f.refeed        = 1'b0;
      v2 = {s.value[5:0], b[5:0]};
      v3 = {s.value[10:0], b[5:0]};
      v4 = {s.value[14:0], b[5:0]};
      if (s.count == 3'd0) begin
         if (!b[7]) begin
            f.emit           = 1'b1;
            f.res.code_point = {13'd0, b};
            f.res.had_error  = 1'b0;
            f.res.seq_length = SEQ_LEN_ONE;
         end else if ((b < LEAD_MIN) || (b > LEAD_MAX)) begin
            f.emit = 1'b1;
            f.res  = error_result(SEQ_LEN_ONE);
         end else begin
            f.st.value = {13'd0, b};
            f.st.count = 3'd1;
         end
      end else if (b[7:6] != 2'b10) begin
         f.emit   = 1'b1;
         f.res    = error_result(s.count);
         f.st     = STATE_CLEAR;
         f.refeed = 1'b1;
      end else begin
         case (s.count)
            3'd1: begin
               if (!v2[11]) begin
                  f.emit = 1'b1;
                  f.res  = finish({9'd0, v2}, MIN_TWO_BYTE, SEQ_LEN_TWO);
                  f.st   = STATE_CLEAR;
               end else begin
                  f.st.value = {9'd0, v2};
                  f.st.count = 3'd2;
               end
            end
            3'd2: begin
               if (v3[16] || (v3[15:10] == HIGH_SURR_TAG)) begin
                  f.st.value = {4'd0, v3};
                  f.st.count = 3'd3;
               end else begin
                  f.emit = 1'b1;
                  f.res  = finish({4'd0, v3}, MIN_THREE_BYTE, SEQ_LEN_THREE);
                  f.st   = STATE_CLEAR;
               end
            end
            default: begin
               f.emit = 1'b1;
               f.res  = finish(v4, SUPP_BASE, SEQ_LEN_FOUR);
               f.st   = STATE_CLEAR;
            end
         endcase
      end
      return f;
   endfunction

endpackage

`default_nettype wire

@@ design/utf8d_queue.sv @@
// -----------------------------------------------------------------------------
// utf8d_queue : result bundle queue
// short fifo of decoded bundles between the decoder and the output stage
// -----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  utf8d_pkg::entry_type         push_entry,
   input  logic                         pop,
   output utf8d_pkg::queue_status_type  status,
   output utf8d_pkg::entry_type         head
);
   import utf8d_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head             = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ design/utf8d_front.sv @@
// -----------------------------------------------------------------------------
// utf8d_front : byte decoder front end
// takes one byte word per cycle while the queue has room and turns it into up to four results
// -----------------------------------------------------------------------------
`default_nettype none

module utf8d_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_end_of_string,
   input  utf8d_pkg::queue_status_type  q_status,
   output logic                         q_push,
   output utf8d_pkg::entry_type         q_entry
);
   import utf8d_pkg::*;

   dec_state_type state_ff, state_in;
   logic [7:0]    held_ff, held_in;
   logic          string_ok_ff, string_ok_in;

   logic          accept;
   logic          waiting;
   logic          cont;
   logic [20:0]   pair_value;
   logic          do_feed;
   dec_state_type fed_from;
   dec_state_type walk_state;
   logic [7:0]    held_next;
   feed_type      feed_a;
   feed_type      feed_b;
   dec_state_type flush_mid;
   logic          walk_waiting;
   logic [2:0]    flush_tail;
   logic          bad;
   logic          ok_now;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign waiting    = (state_ff.count == 3'd3) && (state_ff.value[20:16] == 5'd0);
   assign cont       = (req_in_byte[7:6] == 2'b10);
   assign pair_value = SUPP_BASE + {1'b0, state_ff.value[9:0], held_ff[3:0], req_in_byte[5:0]};
   assign fed_from   = waiting ? replay_state(state_ff.held_count, held_ff) : state_ff;
   assign feed_a     = feed_byte(fed_from, req_in_byte);
   assign feed_b     = feed_byte(STATE_CLEAR, req_in_byte);

   always_comb begin
      q_entry    = '0;
      walk_state = state_ff;
      held_next  = held_ff;
      do_feed    = 1'b0;

      if (waiting) begin
         if ((state_ff.held_count == 2'd0) && (req_in_byte == LEAD_SURROGATE)) begin
            walk_state.held_count = 2'd1;
         end else if ((state_ff.held_count == 2'd1) &&
                      (req_in_byte[7:4] == LOW_SURROGATE_NIB)) begin
            walk_state.held_count = 2'd2;
            held_next             = req_in_byte;
         end else if ((state_ff.held_count == 2'd2) && cont) begin
            q_entry.mask[1] = 1'b1;
            q_entry.slot[1] = finish(pair_value, SUPP_BASE, SEQ_LEN_PAIR);
            walk_state      = STATE_CLEAR;
         end else begin
            // lone high surrogate, held bytes go round again
            q_entry.mask[0] = 1'b1;
            q_entry.slot[0] = error_result(SEQ_LEN_THREE);
            do_feed         = 1'b1;
         end
      end else begin
         do_feed = 1'b1;
      end

      if (do_feed) begin
         q_entry.mask[1] = feed_a.emit;
         q_entry.slot[1] = feed_a.res;
         walk_state      = feed_a.st;
         if (feed_a.refeed) begin
            q_entry.mask[2] = feed_b.emit;
            q_entry.slot[2] = feed_b.res;
            walk_state      = feed_b.st;
         end
      end

      // end of string flush
      flush_mid    = replay_state(walk_state.held_count, held_next);
      walk_waiting = (walk_state.count == 3'd3) && (walk_state.value[20:16] == 5'd0);
      flush_tail   = walk_waiting ? flush_mid.count : walk_state.count;
      if (req_end_of_string) begin
         if (walk_waiting) begin
            q_entry.mask[3] = 1'b1;
            q_entry.slot[3] = error_result(SEQ_LEN_THREE);
         end
         if (flush_tail != 3'd0) begin
            q_entry.mask[4] = 1'b1;
            q_entry.slot[4] = error_result(flush_tail);
         end
      end

      bad = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         bad = bad || (q_entry.mask[i] &&
                       (q_entry.slot[i].had_error || (q_entry.slot[i].seq_length == SEQ_LEN_PAIR)));
      end
      ok_now               = string_ok_ff && !bad;
      q_entry.last         = req_end_of_string;
      q_entry.string_valid = ok_now;

      q_push       = accept && (q_entry.mask != '0);
      state_in     = accept ? (req_end_of_string ? STATE_CLEAR : walk_state) : state_ff;
      held_in      = accept ? held_next : held_ff;
      string_ok_in = accept ? (req_end_of_string || ok_now) : string_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         string_ok_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         string_ok_ff <= string_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

@@ design/utf8d_back.sv @@
// -----------------------------------------------------------------------------
// utf8d_back : result output stage
// walks the queued bundle one result per cycle, unless rsp_ready stalls it, into the registered output
// -----------------------------------------------------------------------------
`default_nettype none

module utf8d_back (
   input  logic                         clock,
   input  logic                         reset,
   input  utf8d_pkg::entry_type         head,
   input  utf8d_pkg::queue_status_type  q_status,
   output logic                         q_pop,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [20:0]                  rsp_code_point,
   output logic                         rsp_had_error,
   output logic [2:0]                   rsp_seq_length,
   output logic                         rsp_is_last,
   output logic                         rsp_string_valid
);
   import utf8d_pkg::*;

   logic [NUM_SLOTS-1:0] sent_ff, sent_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff;
   logic                 is_last_ff;
   logic                 string_valid_ff;

   logic [NUM_SLOTS-1:0] pending;
   logic [NUM_SLOTS-1:0] pick;
   logic [NUM_SLOTS-1:0] rest;
   logic                 load;
   logic                 last_slot;
   result_type           picked;

   always_comb begin
      pending   = q_status.not_empty ? (head.mask & ~sent_ff) : '0;
      pick      = pending & (~pending + NUM_SLOTS'(1));
      rest      = pending & ~pick;
      last_slot = (rest == '0);
      load      = (pending != '0) && (!rsp_valid_ff || rsp_ready);
      picked    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (pick[i]) begin
            picked = head.slot[i];
         end
      end
      q_pop        = load && last_slot;
      sent_in      = load ? (last_slot ? '0 : (sent_ff | pick)) : sent_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff       <= picked;
         is_last_ff      <= head.last && last_slot;
         string_valid_ff <= head.last && last_slot && head.string_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = result_ff.code_point;
   assign rsp_had_error    = result_ff.had_error;
   assign rsp_seq_length   = result_ff.seq_length;
   assign rsp_is_last      = is_last_ff;
   assign rsp_string_valid = string_valid_ff;

endmodule

`default_nettype wire

@@ design/utf8_decoder_cesu8_fixup.sv @@
// -----------------------------------------------------------------------------
// utf8_decoder_cesu8_fixup : utf-8 decoder with cesu-8 surrogate pair joining
// Takes one nonzero string byte word per cycle and gives decoded code points,
// 0x3F with the length used for malformed sequences, and an end of string flag
// with a whole-string validity bit on the last result. A byte is accepted
// whenever the bundle queue (QUEUE_DEPTH entries) has room; the decoder turns
// it into zero to four results at once, and the output stage sends one result
// per cycle while rsp_ready allows. Each result passes through the bundle queue
// and then the registered output stage after its byte is accepted.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module utf8_decoder_cesu8_fixup #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_had_error,
   output logic [2:0]  rsp_seq_length,
   output logic        rsp_is_last,
   output logic        rsp_string_valid
);
   import utf8d_pkg::*;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   entry_type        q_entry;
   entry_type        q_head;

   utf8d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_entry           (q_entry)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .status     (q_status),
      .head       (q_head)
   );

   utf8d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (q_head),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_code_point   (rsp_code_point),
      .rsp_had_error    (rsp_had_error),
      .rsp_seq_length   (rsp_seq_length),
      .rsp_is_last      (rsp_is_last),
      .rsp_string_valid (rsp_string_valid)
   );

   `UTF8D_ASSERT(a_no_push_when_full, clock, reset, q_push |-> !q_status.full, "push into full queue")
   `UTF8D_ASSERT(a_valid_only_on_last, clock, reset, (rsp_valid && rsp_string_valid) |-> rsp_is_last, "string valid away from last result")
   `UTF8D_NEVER(a_error_replacement, clock, reset, rsp_valid && rsp_had_error && (rsp_code_point != CP_REPLACEMENT), "error result without replacement code")
   `UTF8D_NEVER(a_pair_not_valid, clock, reset, rsp_valid && (rsp_seq_length == SEQ_LEN_PAIR) && rsp_string_valid, "joined pair marked string valid")

endmodule

`default_nettype wire
